// File: rtl/core/tcphq_pkg.sv
// ----------------------------------------------------------------------------
// tcphq_pkg: shared codes for the three-class priority queue
// Operation, status and class codes, per-cell control bundle, default sizes.
// ----------------------------------------------------------------------------
package tcphq_pkg;

  localparam int unsigned DEF_CLASS_DEPTH = 256;
  localparam int unsigned DEF_KEY_BITS    = 32;
  localparam int unsigned DEF_ID_BITS     = 16;

  typedef enum logic [1:0] {
    MODE_INSERT  = 2'd0,
    MODE_EXTRACT = 2'd1,
    MODE_PEEK    = 2'd2,
    MODE_NONE    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_BAD_URG = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CLS_LOW  = 2'd0,
    CLS_MID  = 2'd1,
    CLS_HIGH = 2'd2,
    CLS_BAD  = 2'd3
  } class_e;

  // per-chain command, broadcast to every cell of that chain
  typedef struct packed {
    logic ins;
    logic ext;
  } cell_ctl_t;

endpackage

// File: rtl/core/tcphq_if.sv
// ----------------------------------------------------------------------------
// tcphq_if: request and response channels
// Valid/ready channels carrying one request or one response per transfer.
// ----------------------------------------------------------------------------
interface tcphq_req_if #(
  parameter int unsigned KEY_W = 32,
  parameter int unsigned ID_W  = 16
);
  logic             valid;
  logic             ready;
  logic [1:0]       mode;
  logic [1:0]       urgency;
  logic [KEY_W-1:0] sort_key;
  logic [ID_W-1:0]  item_id;

  modport source (output valid, mode, urgency, sort_key, item_id, input ready);
  modport sink   (input valid, mode, urgency, sort_key, item_id, output ready);
endinterface

interface tcphq_rsp_if #(
  parameter int unsigned KEY_W = 32,
  parameter int unsigned ID_W  = 16
);
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [ID_W-1:0]  out_id;
  logic [KEY_W-1:0] out_key;
  logic [1:0]       out_class;
  logic             all_empty;

  modport source (output valid, status, out_id, out_key, out_class, all_empty,
                  input ready);
  modport sink   (input valid, status, out_id, out_key, out_class, all_empty,
                  output ready);
endinterface

// File: rtl/core/three_class_priority_heap_queue.sv
// ----------------------------------------------------------------------------
// three_class_priority_heap_queue: strict-priority queue over three classes
// Insert, extract-minimum and peek over high, middle and low classes.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  in_i    | in  | mode, urgency, sort_key, item_id
//  out_o   | out | status, out_id, out_key, out_class, all_empty
//
// Every request is served in a single step: each class is a chain of cells that
// all shift or hold in parallel, so insert and extract are single steps.
// The response register decouples the sides; a new request is taken while
// out_o is empty or being drained in the same cycle. Reset clears the cell
// valid bits and the response valid bit; no clearing pass is needed.
// ----------------------------------------------------------------------------
module three_class_priority_heap_queue import tcphq_pkg::*; #(
  parameter int unsigned CLASS_DEPTH = DEF_CLASS_DEPTH,
  parameter int unsigned KEY_BITS    = DEF_KEY_BITS,
  parameter int unsigned ID_BITS     = DEF_ID_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tcphq_req_if.sink  in_i,
  tcphq_rsp_if.source out_o
);

  cell_ctl_t         ctl [3];
  logic [KEY_BITS-1:0] hkey [3];
  logic [ID_BITS-1:0]  hid  [3];
  logic              empty [3];
  logic              single [3];
  logic              full [3];

  logic              acc;
  logic [1:0]        sel;
  logic              none_left;
  logic              out_valid_q;
  logic [1:0]        status_q, status_d;
  logic [ID_BITS-1:0]  oid_q, oid_d;
  logic [KEY_BITS-1:0] okey_q, okey_d;
  logic [1:0]        ocls_q, ocls_d;
  logic              aempty_q, aempty_d;

  for (genvar c = 0; c < 3; c++) begin : g_cls
    tcphq_chain #(.DEPTH(CLASS_DEPTH), .KEY_W(KEY_BITS), .ID_W(ID_BITS)) u_chain (
      .clk_i,
      .rst_ni,
      .ctl_i     (ctl[c]),
      .new_key_i (in_i.sort_key),
      .new_id_i  (in_i.item_id),
      .head_key_o(hkey[c]),
      .head_id_o (hid[c]),
      .empty_o   (empty[c]),
      .single_o  (single[c]),
      .full_o    (full[c])
    );
  end

  assign acc       = in_i.valid && in_i.ready;
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign none_left = empty[CLS_HIGH] && empty[CLS_MID] && empty[CLS_LOW];

  always_comb begin
    if (!empty[CLS_HIGH])     sel = CLS_HIGH;
    else if (!empty[CLS_MID]) sel = CLS_MID;
    else                      sel = CLS_LOW;
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ctl[c] = '0;
    end
    status_d = ST_OK;
    oid_d    = '0;
    okey_d   = '0;
    ocls_d   = CLS_LOW;
    aempty_d = none_left;
    case (in_i.mode)
      MODE_INSERT: begin
        if (in_i.urgency == CLS_BAD) begin
          status_d = ST_BAD_URG;
        end else if (full[in_i.urgency]) begin
          status_d = ST_FULL;
        end else begin
          ctl[in_i.urgency].ins = acc;
          aempty_d = 1'b0;
        end
      end
      MODE_EXTRACT, MODE_PEEK: begin
        if (none_left) begin
          status_d = ST_EMPTY;
        end else begin
          oid_d  = hid[sel];
          okey_d = hkey[sel];
          ocls_d = sel;
          if (in_i.mode == MODE_EXTRACT) begin
            ctl[sel].ext = acc;
            // only lower classes can still be occupied when sel drains
            aempty_d = single[sel] && (sel == CLS_LOW ||
                       (sel == CLS_MID && empty[CLS_LOW]) ||
                       (empty[CLS_MID] && empty[CLS_LOW]));
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (acc) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      status_q <= status_d;
      oid_q    <= oid_d;
      okey_q   <= okey_d;
      ocls_q   <= ocls_d;
      aempty_q <= aempty_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.status    = status_q;
  assign out_o.out_id    = oid_q;
  assign out_o.out_key   = okey_q;
  assign out_o.out_class = ocls_q;
  assign out_o.all_empty = aempty_q;

  a_insert_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && in_i.mode == MODE_INSERT && in_i.urgency != CLS_BAD && !full[in_i.urgency]
    |=> out_valid_q && status_q == ST_OK && !aempty_q && !none_left)
    else $error("insert did not leave queue occupied");

  a_empty_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && in_i.mode == MODE_EXTRACT && none_left |=> status_q == ST_EMPTY && aempty_q)
    else $error("extract on empty queue misreported");

  a_all_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> aempty_q == none_left)
    else $error("all_empty disagrees with chain state");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |-> !in_i.ready)
    else $error("request taken while response stalled");

endmodule

// File: rtl/core/tcphq_cell.sv
// ----------------------------------------------------------------------------
// tcphq_cell: one slot of a sorted chain
// Holds one entry; on insert it keeps, takes the new entry or takes its left
// neighbor; on extract it takes its right neighbor.
// ----------------------------------------------------------------------------
module tcphq_cell import tcphq_pkg::*; #(
  parameter int unsigned KEY_W = DEF_KEY_BITS,
  parameter int unsigned ID_W  = DEF_ID_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctl_t        ctl_i,
  input  logic [KEY_W-1:0] new_key_i,
  input  logic [ID_W-1:0]  new_id_i,
  input  logic [KEY_W-1:0] left_key_i,
  input  logic [ID_W-1:0]  left_id_i,
  input  logic             left_valid_i,
  input  logic             left_shift_i,
  input  logic [KEY_W-1:0] right_key_i,
  input  logic [ID_W-1:0]  right_id_i,
  input  logic             right_valid_i,
  output logic [KEY_W-1:0] key_o,
  output logic [ID_W-1:0]  id_o,
  output logic             valid_o,
  output logic             shift_o
);

  logic [KEY_W-1:0] key_q, key_d;
  logic [ID_W-1:0]  id_q, id_d;
  logic             valid_q, valid_d;
  logic             new_first;

  assign new_first = (new_key_i < key_q) || ((new_key_i == key_q) && (new_id_i < id_q));
  // our entry moves right when a valid one sits behind the new entry
  assign shift_o   = valid_q && new_first;

  always_comb begin
    key_d   = key_q;
    id_d    = id_q;
    valid_d = valid_q;
    if (ctl_i.ext) begin
      key_d   = right_key_i;
      id_d    = right_id_i;
      valid_d = right_valid_i;
    end else if (ctl_i.ins) begin
      if (left_shift_i) begin
        key_d   = left_key_i;
        id_d    = left_id_i;
        valid_d = 1'b1;
      end else if ((!valid_q && left_valid_i) || (valid_q && new_first)) begin
        // only the insertion point takes the new entry: the first free slot or the first slot holding a later entry
        key_d   = new_key_i;
        id_d    = new_id_i;
        valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    id_q  <= id_d;
  end

  assign key_o   = key_q;
  assign id_o    = id_q;
  assign valid_o = valid_q;

endmodule

// File: rtl/core/tcphq_chain.sv
// ----------------------------------------------------------------------------
// tcphq_chain: sorted chain of cells for one class
// Entries stay ordered by (key, id) with the minimum in cell 0.
// ----------------------------------------------------------------------------
module tcphq_chain import tcphq_pkg::*; #(
  parameter int unsigned DEPTH = DEF_CLASS_DEPTH,
  parameter int unsigned KEY_W = DEF_KEY_BITS,
  parameter int unsigned ID_W  = DEF_ID_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctl_t        ctl_i,
  input  logic [KEY_W-1:0] new_key_i,
  input  logic [ID_W-1:0]  new_id_i,
  output logic [KEY_W-1:0] head_key_o,
  output logic [ID_W-1:0]  head_id_o,
  output logic             empty_o,
  output logic             single_o,
  output logic             full_o
);

  logic [KEY_W-1:0] key_w   [DEPTH+1];
  logic [ID_W-1:0]  id_w    [DEPTH+1];
  logic             valid_w [DEPTH+1];
  logic             shift_w [DEPTH];

  // tail stub past the last cell
  assign key_w[DEPTH]   = '0;
  assign id_w[DEPTH]    = '0;
  assign valid_w[DEPTH] = 1'b0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [KEY_W-1:0] lkey;
    logic [ID_W-1:0]  lid;
    logic             lvalid;
    logic             lshift;
    if (g == 0) begin : g_first
      assign lkey   = '0;
      assign lid    = '0;
      assign lvalid = 1'b1;
      assign lshift = 1'b0;
    end else begin : g_rest
      assign lkey   = key_w[g-1];
      assign lid    = id_w[g-1];
      assign lvalid = valid_w[g-1];
      assign lshift = shift_w[g-1];
    end
    tcphq_cell #(.KEY_W(KEY_W), .ID_W(ID_W)) u_cell (
      .clk_i,
      .rst_ni,
      .ctl_i,
      .new_key_i,
      .new_id_i,
      .left_key_i   (lkey),
      .left_id_i    (lid),
      .left_valid_i (lvalid),
      .left_shift_i (lshift),
      .right_key_i  (key_w[g+1]),
      .right_id_i   (id_w[g+1]),
      .right_valid_i(valid_w[g+1]),
      .key_o        (key_w[g]),
      .id_o         (id_w[g]),
      .valid_o      (valid_w[g]),
      .shift_o      (shift_w[g])
    );
  end

  assign head_key_o = key_w[0];
  assign head_id_o  = id_w[0];
  assign empty_o    = !valid_w[0];
  assign single_o   = valid_w[0] && !valid_w[1];
  assign full_o     = valid_w[DEPTH-1];

endmodule
